FILE: src/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared widths, constants and phase codes for the finder pattern row scanner.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int PIXEL_W   = 8;
   localparam int ROW_W     = 12;
   localparam int OUT_W     = 13;
   localparam int RUN_W     = 12;
   localparam int NUM_RUNS  = 5;
   localparam int PHASE_W   = 3;
   localparam int TOTAL_W   = 15;

   localparam int ROW_WIDTH_MAX_DEFAULT = 4096;
   localparam int ROW_COUNT_MAX         = 4096;

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd128;
   localparam logic [RUN_W-1:0]   RUN_MAX         = 12'hFFF;
   localparam logic [OUT_W-1:0]   OUT_MAX         = 13'h1FFF;
   localparam logic [ROW_W-1:0]   FOUND_ROW_MAX   = ROW_W'(ROW_COUNT_MAX - 1);

   // floor(x / 7) = (x * DIV7_RECIP) >> DIV7_SHIFT for x below 2^15
   localparam logic [TOTAL_W-1:0] DIV7_RECIP = 15'd18725;
   localparam int                 DIV7_SHIFT = 17;
   localparam logic [TOTAL_W-1:0] MIN_TOTAL  = 15'd7;
   localparam logic [TOTAL_W-1:0] CEIL_BIAS  = 15'd6;

   // run being counted: black, white, black (center), white, black
   localparam logic [PHASE_W-1:0] PH_BLACK_L = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WHITE_L = 3'd1;
   localparam logic [PHASE_W-1:0] PH_CENTER  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_WHITE_R = 3'd3;
   localparam logic [PHASE_W-1:0] PH_BLACK_R = 3'd4;

   typedef logic [RUN_W-1:0] run_count_type;

endpackage

FILE: src/frs_if.sv
// ----------------------------------------------------------------------------
// frs_req_if / frs_rsp_if
// Valid/ready channels for pixel words in and detection words out.
// ----------------------------------------------------------------------------
interface frs_req_if
   import frs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               row_start;
   logic [ROW_W-1:0]   row_index;

   modport source (output valid, output pixel, output row_start, output row_index,
                   input ready);
   modport sink   (input valid, input pixel, input row_start, input row_index,
                   output ready);
endinterface

interface frs_rsp_if
   import frs_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [OUT_W-1:0] center_twice;
   logic [OUT_W-1:0] total_width;
   logic [ROW_W-1:0] found_row;

   modport source (output valid, output found, output center_twice,
                   output total_width, output found_row, input ready);
   modport sink   (input valid, input found, input center_twice,
                   input total_width, input found_row, output ready);
endinterface

FILE: src/finder_pattern_row_scan_core.sv
// ----------------------------------------------------------------------------
// finder_pattern_row_scan_core
// Run-length scan of grey pixel rows for the 1:1:3:1:1 finder pattern.
// ----------------------------------------------------------------------------
// One pixel word is accepted per clock and every pixel yields one result word.
// A word passes an input register, then the run-count update and ratio test
// (five-run sum, multiply by the reciprocal of 7, tolerance compares) are
// combinational and load the state and the result register; the sustained
// rate is one word per cycle, limited only by rsp_chan.ready.
// csr_wr_data sets the black threshold (reset 128); write it while no words
// are in flight.
module finder_pattern_row_scan_core
   import frs_pkg::*;
#(
   parameter int ROW_WIDTH_MAX = ROW_WIDTH_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [PIXEL_W-1:0] csr_wr_data,
   frs_req_if.sink            req_chan,
   frs_rsp_if.source          rsp_chan
);

   localparam int COL_W = $clog2(ROW_WIDTH_MAX);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_WIDTH_MAX - 1);
   localparam int DIF_W = ((COL_W + 1) > TOTAL_W) ? (COL_W + 1) : TOTAL_W;

   logic [PIXEL_W-1:0] threshold_ff;

   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_start_ff;
   logic [ROW_W-1:0]   s1_row_ff;

   run_count_type      runs_ff [NUM_RUNS];
   run_count_type      runs_in [NUM_RUNS];
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [COL_W-1:0]   col;
   logic               hit;

   logic               rsp_valid_ff;
   logic               found_ff;
   logic [OUT_W-1:0]   center_ff;
   logic [OUT_W-1:0]   total_ff;
   logic [ROW_W-1:0]   found_row_ff;

   logic               advance;
   logic               fire;

   logic [TOTAL_W-1:0] total;
   logic [2*TOTAL_W-1:0] div_prod;
   logic [RUN_W-1:0]   mod_size;
   logic [RUN_W-1:0]   tol;
   logic [13:0]        mod3;
   logic [13:0]        tol3;
   logic               ratio_ok;

   logic [DIF_W-1:0]   col_dbl;
   logic [DIF_W-1:0]   center_sub;
   logic [DIF_W-1:0]   center_dif;
   logic [OUT_W-1:0]   center_out;
   logic [OUT_W-1:0]   total_out;
   logic [ROW_W-1:0]   row_out;

   function automatic logic [13:0] abs_diff(input logic [13:0] a, input logic [13:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic run_count_type sat_inc(input run_count_type x);
      return (x == RUN_MAX) ? x : x + 1'b1;
   endfunction

   // handshake
   assign advance       = !rsp_valid_ff || rsp_chan.ready;
   assign fire          = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_pixel_ff <= req_chan.pixel;
         s1_start_ff <= req_chan.row_start;
         s1_row_ff   <= req_chan.row_index;
      end
   end

   // ratio test on the stored runs
   always_comb begin
      total = TOTAL_W'(runs_ff[0]) + TOTAL_W'(runs_ff[1]) + TOTAL_W'(runs_ff[2])
            + TOTAL_W'(runs_ff[3]) + TOTAL_W'(runs_ff[4]);
      div_prod = (2*TOTAL_W)'(total + CEIL_BIAS) * (2*TOTAL_W)'(DIV7_RECIP);
      mod_size = div_prod[DIV7_SHIFT +: RUN_W];
      tol      = mod_size >> 1;
      mod3     = 14'(mod_size) + 14'(mod_size) + 14'(mod_size);
      tol3     = 14'(tol) + 14'(tol) + 14'(tol);
      ratio_ok = (runs_ff[0] != '0) && (runs_ff[1] != '0) && (runs_ff[2] != '0)
              && (runs_ff[3] != '0) && (runs_ff[4] != '0) && (total >= MIN_TOTAL)
              && (abs_diff(14'(mod_size), 14'(runs_ff[0])) < 14'(tol))
              && (abs_diff(14'(mod_size), 14'(runs_ff[1])) < 14'(tol))
              && (abs_diff(mod3, 14'(runs_ff[2])) < tol3)
              && (abs_diff(14'(mod_size), 14'(runs_ff[3])) < 14'(tol))
              && (abs_diff(14'(mod_size), 14'(runs_ff[4])) < 14'(tol));
   end

   // run-count and phase update
   always_comb begin
      logic [PHASE_W-1:0] ph;
      logic [PHASE_W-1:0] bump_ph;
      logic               do_bump;
      logic               black;

      ph      = (s1_start_ff || (phase_ff > PH_BLACK_R)) ? PH_BLACK_L : phase_ff;
      col     = s1_start_ff ? '0 : column_ff;
      black   = s1_pixel_ff < threshold_ff;
      hit     = 1'b0;
      do_bump = 1'b0;
      bump_ph = ph;
      for (int k = 0; k < NUM_RUNS; k++) begin
         runs_in[k] = s1_start_ff ? '0 : runs_ff[k];
      end
      phase_in  = ph;
      column_in = (col == COL_LAST) ? col : col + 1'b1;

      if (black) begin
         do_bump = 1'b1;
         bump_ph = ph[0] ? ph + 1'b1 : ph;
      end else if (ph[0]) begin
         do_bump = 1'b1;
      end else if (ph != PH_BLACK_R) begin
         do_bump = 1'b1;
         bump_ph = ph + 1'b1;
      end else if (ratio_ok) begin
         hit = 1'b1;
         for (int k = 0; k < NUM_RUNS; k++) begin
            runs_in[k] = '0;
         end
         bump_ph = PH_BLACK_L;
      end else begin
         // drop the first two runs, the ending white pixel opens the right white run
         runs_in[0] = runs_ff[2];
         runs_in[1] = runs_ff[3];
         runs_in[2] = runs_ff[4];
         runs_in[3] = run_count_type'(1);
         runs_in[4] = '0;
         bump_ph    = PH_WHITE_R;
      end

      phase_in = bump_ph;
      if (do_bump) begin
         for (int k = 0; k < NUM_RUNS; k++) begin
            if (PHASE_W'(k) == bump_ph) begin
               runs_in[k] = sat_inc(runs_in[k]);
            end
         end
      end
   end

   // result fields
   always_comb begin
      col_dbl    = DIF_W'({col, 1'b0});
      center_sub = DIF_W'({runs_ff[4], 1'b0}) + DIF_W'({runs_ff[3], 1'b0})
                 + DIF_W'(runs_ff[2]);
      center_dif = col_dbl - center_sub;
      if (col_dbl < center_sub) begin
         center_out = '0;
      end else if (center_dif > DIF_W'(OUT_MAX)) begin
         center_out = OUT_MAX;
      end else begin
         center_out = center_dif[OUT_W-1:0];
      end
      total_out = (total > TOTAL_W'(OUT_MAX)) ? OUT_MAX : total[OUT_W-1:0];
      row_out   = (s1_row_ff > FOUND_ROW_MAX) ? FOUND_ROW_MAX : s1_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_RUNS; k++) begin
            runs_ff[k] <= '0;
         end
         phase_ff  <= PH_BLACK_L;
         column_ff <= '0;
      end else if (fire) begin
         runs_ff   <= runs_in;
         phase_ff  <= phase_in;
         column_ff <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         found_ff     <= hit;
         center_ff    <= hit ? center_out : '0;
         total_ff     <= hit ? total_out : '0;
         found_row_ff <= hit ? row_out : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.center_twice = center_ff;
   assign rsp_chan.total_width  = total_ff;
   assign rsp_chan.found_row    = found_row_ff;

endmodule
